// ===== rtl/cdfl_pkg.sv =====
// Shared types, constants, saturating helpers and the step table for the
// channel deposition flux limiter. Depends on nothing; every other file uses it.
`default_nettype none

package cdfl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OP_W          = 3;
  localparam int GEO_W         = 31;
  localparam int DATA_W        = 32;
  localparam int PFRAC_W       = 17;
  localparam int TS_W          = 31;
  localparam int PC_W          = 4;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_GEOM   = 3'd0,
    OP_START  = 3'd1,
    OP_SOLID  = 3'd2,
    OP_LOSS   = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    A_SS, A_T0, A_DH, A_FLOW, A_FLUX, A_VOL, A_LOSS
  } a_sel_t;

  typedef enum logic [2:0] {
    B_HH, B_TW, B_LEN, B_CONC, B_FRAC, B_DT, B_FP
  } b_sel_t;

  typedef enum logic [1:0] {
    DST_T0, DST_T1, DST_TP, DST_VOL
  } dst_t;

  typedef enum logic [2:0] {
    ALU_NONE       = 3'd0,
    ALU_START_CHEM = 3'd1,
    ALU_ACC_LOSS   = 3'd2,
    ALU_ADD_BW     = 3'd3,
    ALU_ADD_AREA   = 3'd4,
    ALU_ACC_FLUX   = 3'd5,
    ALU_AVAIL      = 3'd6
  } alu_t;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_PASS = 2'd1,
    RES_DIV  = 2'd2
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_ALU, ST_CMP, ST_DIV, ST_OUT
  } state_t;

  // One step of a sequence: a product, where it goes, and an optional
  // operation that follows it.
  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    dst_t   dst;
    alu_t   alu;
    logic   last;
    logic   fin;
  } uop_t;

  typedef struct packed {
    logic   latch_in;
    logic   mul_start;
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   mul_wr;
    dst_t   dst;
    alu_t   alu;
    logic   div_start;
    res_t   res;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic pot_gt;
    logic out_free;
  } sts_t;

  localparam logic [PC_W-1:0] PC_GEOM   = 4'd0;
  localparam logic [PC_W-1:0] PC_SOLID  = 4'd4;
  localparam logic [PC_W-1:0] PC_FINISH = 4'd6;

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      4'd0:    u = '{A_SS,   B_HH,   DST_T0,  ALU_ADD_BW,   1'b0, 1'b0};
      4'd1:    u = '{A_T0,   B_HH,   DST_T0,  ALU_NONE,     1'b0, 1'b0};
      4'd2:    u = '{A_DH,   B_TW,   DST_T1,  ALU_ADD_AREA, 1'b0, 1'b0};
      4'd3:    u = '{A_T0,   B_LEN,  DST_VOL, ALU_NONE,     1'b1, 1'b0};
      4'd4:    u = '{A_FLOW, B_CONC, DST_T0,  ALU_NONE,     1'b0, 1'b0};
      4'd5:    u = '{A_T0,   B_FRAC, DST_T1,  ALU_ACC_FLUX, 1'b1, 1'b0};
      4'd6:    u = '{A_FLUX, B_DT,   DST_TP,  ALU_NONE,     1'b0, 1'b0};
      4'd7:    u = '{A_VOL,  B_CONC, DST_T0,  ALU_NONE,     1'b0, 1'b0};
      4'd8:    u = '{A_T0,   B_FP,   DST_T0,  ALU_NONE,     1'b0, 1'b0};
      4'd9:    u = '{A_LOSS, B_DT,   DST_T1,  ALU_AVAIL,    1'b1, 1'b1};
      default: u = '{A_T0,   B_HH,   DST_T1,  ALU_NONE,     1'b1, 1'b0};
    endcase
    return u;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_neg64(input logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cdfl_qmul.sv =====
// Shared fixed-point multiplier: 64 x 64 signed magnitude product built from
// four 32 x 32 partial products, truncated and saturated. Uses cdfl_pkg.
`default_nettype none

module cdfl_qmul #(
  parameter int FRAC_BITS = cdfl_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      result
);

  logic         busy;
  logic [2:0]   cnt;
  logic         neg;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [1:0]   pidx;
  logic [127:0] pp_shifted;
  logic [63:0]  mag;
  logic         ovf;

  // Partial product order: low x low, low x high, high x low, high x high.
  assign a_half = cnt[1] ? ua[63:32] : ua[31:0];
  assign b_half = cnt[0] ? ub[63:32] : ub[31:0];
  assign pidx   = 2'(cnt - 3'd1);

  always_comb begin
    unique case (pidx)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd3:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        if (done) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[63] ^ b[63];
      ua  <= a[63] ? 64'd0 - a : a;
      ub  <= b[63] ? 64'd0 - b : b;
      acc <= '0;
    end else if (busy) begin
      if (cnt <= 3'd3) begin
        pp <= a_half * b_half;
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + pp_shifted;
      end
    end
  end

  assign done = busy && (cnt == 3'd5);
  assign mag  = acc[FRAC_BITS +: 64];
  assign ovf  = (acc >> (63 + FRAC_BITS)) != 128'd0;

  always_comb begin
    if (!neg) begin
      result = ovf ? cdfl_pkg::S64_MAX : mag;
    end else begin
      result = ovf ? cdfl_pkg::S64_MIN : -mag;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cdfl_div.sv =====
// Restoring divider, one quotient bit a cycle: (available << FRAC_BITS) / time
// step, saturated to the positive 32-bit range. Uses cdfl_pkg.
`default_nettype none

module cdfl_div #(
  parameter int FRAC_BITS = cdfl_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [62:0]               dividend,
  input  wire logic [cdfl_pkg::TS_W-1:0] divisor,
  output logic                           done,
  output logic [30:0]                    quotient
);

  localparam int NW = 63 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic                      busy;
  logic [CW-1:0]             cnt;
  logic [NW-1:0]             num;
  logic [cdfl_pkg::TS_W-1:0] d;
  logic [30:0]               rem;
  logic [31:0]               q;
  logic                      ovf;
  logic [31:0]               rem_sh;
  logic [31:0]               rem_sub;
  logic                      ge;

  assign rem_sh  = {rem, num[NW-1]};
  assign ge      = rem_sh >= {1'b0, d};
  assign rem_sub = rem_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (done) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= {dividend, {FRAC_BITS{1'b0}}};
      d   <= divisor;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy && !done) begin
      rem <= ge ? rem_sub[30:0] : rem_sh[30:0];
      q   <= {q[30:0], ge};
      ovf <= ovf | q[31];
      num <= num << 1;
    end
  end

  assign done     = busy && (cnt == CW'(NW));
  assign quotient = (ovf || q[31]) ? 31'h7FFF_FFFF : q[30:0];

endmodule

`default_nettype wire

// ===== rtl/cdfl_datapath.sv =====
// Datapath: node and chemical state, operand selection, the shared multiplier,
// the divider and the result register. Uses cdfl_pkg, cdfl_qmul and cdfl_div.
`default_nettype none

module cdfl_datapath #(
  parameter int FRAC_BITS = cdfl_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cdfl_pkg::cmd_t                cmd,
  output cdfl_pkg::sts_t                     sts,
  input  wire logic                          cfg_we,
  input  wire logic [cdfl_pkg::TS_W-1:0]     cfg_data,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    water_depth,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    bank_height,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    side_slope,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    top_width,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    bottom_width,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    reach_length,
  input  wire logic signed [31:0]            concentration,
  input  wire logic signed [31:0]            deposition_flow,
  input  wire logic [cdfl_pkg::PFRAC_W-1:0]  particulate_fraction,
  input  wire logic signed [31:0]            loss_flux,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [31:0]                 deposition_flux,
  output logic                               was_limited
);

  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam int GW = cdfl_pkg::GEO_W;

  logic [cdfl_pkg::TS_W-1:0]    time_step;
  logic signed [63:0]           water_volume;
  logic signed [31:0]           chem_concentration;
  logic signed [63:0]           flux_sum;
  logic [31:0]                  fraction_sum;
  logic signed [63:0]           loss_sum;

  logic [GW-1:0]                h;
  logic [GW-1:0]                hb;
  logic [GW-1:0]                ss;
  logic [GW-1:0]                tw;
  logic [GW-1:0]                bw;
  logic [GW-1:0]                len;
  logic signed [31:0]           flow;
  logic [cdfl_pkg::PFRAC_W-1:0] frac;

  logic signed [63:0]           t0;
  logic signed [63:0]           t1;
  logic signed [63:0]           tp;
  logic [31:0]                  res_flux;
  logic                         res_lim;

  logic [GW-1:0]                hh;
  logic [GW-1:0]                dh;
  logic signed [63:0]           fp;
  logic signed [63:0]           op_a;
  logic signed [63:0]           op_b;
  logic signed [63:0]           mul_res;
  logic                         mul_done;
  logic                         div_done;
  logic [30:0]                  div_q;
  logic [32:0]                  frac_add;
  logic [31:0]                  frac_next;
  logic signed [63:0]           avail_raw;
  logic signed [63:0]           avail;
  logic                         result_valid_next;

  // Below bank height the trapezoid takes the whole depth; above it a
  // rectangle of the top width covers the excess depth.
  assign hh = (h <= hb) ? h : hb;
  assign dh = (h > hb) ? h - hb : '0;
  assign fp = (fraction_sum > ONE_Q[31:0]) ? $signed(ONE_Q) : $signed({32'd0, fraction_sum});

  always_comb begin
    unique case (cmd.a_sel)
      cdfl_pkg::A_SS:   op_a = {33'd0, ss};
      cdfl_pkg::A_T0:   op_a = t0;
      cdfl_pkg::A_DH:   op_a = {33'd0, dh};
      cdfl_pkg::A_FLOW: op_a = {{32{flow[31]}}, flow};
      cdfl_pkg::A_FLUX: op_a = flux_sum;
      cdfl_pkg::A_VOL:  op_a = water_volume;
      cdfl_pkg::A_LOSS: op_a = loss_sum;
      default:          op_a = t0;
    endcase
    unique case (cmd.b_sel)
      cdfl_pkg::B_HH:   op_b = {33'd0, hh};
      cdfl_pkg::B_TW:   op_b = {33'd0, tw};
      cdfl_pkg::B_LEN:  op_b = {33'd0, len};
      cdfl_pkg::B_CONC: op_b = {{32{chem_concentration[31]}}, chem_concentration};
      cdfl_pkg::B_FRAC: op_b = {{(64 - cdfl_pkg::PFRAC_W){1'b0}}, frac};
      cdfl_pkg::B_DT:   op_b = {33'd0, time_step};
      cdfl_pkg::B_FP:   op_b = fp;
      default:          op_b = fp;
    endcase
  end

  cdfl_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (op_a),
    .b      (op_b),
    .done   (mul_done),
    .result (mul_res)
  );

  cdfl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (t0[62:0]),
    .divisor  (time_step),
    .done     (div_done),
    .quotient (div_q)
  );

  assign frac_add  = {1'b0, fraction_sum} + {{(33 - cdfl_pkg::PFRAC_W){1'b0}}, frac};
  assign frac_next = frac_add[32] ? 32'hFFFF_FFFF : frac_add[31:0];
  assign avail_raw = cdfl_pkg::sat_add64(t0, cdfl_pkg::sat_neg64(t1));
  assign avail     = avail_raw[63] ? 64'sd0 : avail_raw;

  always_comb begin
    if (cmd.out_load) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step          <= ONE_Q[cdfl_pkg::TS_W-1:0];
      water_volume       <= '0;
      chem_concentration <= '0;
      flux_sum           <= '0;
      fraction_sum       <= '0;
      loss_sum           <= '0;
      result_valid       <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (cfg_we) begin
        time_step <= cfg_data;
      end
      if (cmd.mul_wr && cmd.dst == cdfl_pkg::DST_VOL) begin
        water_volume <= mul_res;
      end
      unique case (cmd.alu)
        cdfl_pkg::ALU_START_CHEM: begin
          chem_concentration <= concentration;
          flux_sum           <= '0;
          fraction_sum       <= '0;
          loss_sum           <= '0;
        end
        cdfl_pkg::ALU_ACC_LOSS: begin
          loss_sum <= cdfl_pkg::sat_add64(loss_sum, {{32{loss_flux[31]}}, loss_flux});
        end
        cdfl_pkg::ALU_ACC_FLUX: begin
          flux_sum     <= cdfl_pkg::sat_add64(flux_sum, t1);
          fraction_sum <= frac_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      h    <= water_depth;
      hb   <= bank_height;
      ss   <= side_slope;
      tw   <= top_width;
      bw   <= bottom_width;
      len  <= reach_length;
      flow <= deposition_flow;
      frac <= particulate_fraction;
    end
    if (cmd.mul_wr) begin
      unique case (cmd.dst)
        cdfl_pkg::DST_T0: t0 <= mul_res;
        cdfl_pkg::DST_T1: t1 <= mul_res;
        cdfl_pkg::DST_TP: tp <= mul_res;
        default: ;
      endcase
    end
    unique case (cmd.alu)
      cdfl_pkg::ALU_ADD_BW:   t0 <= cdfl_pkg::sat_add64({33'd0, bw}, t0);
      cdfl_pkg::ALU_ADD_AREA: t0 <= cdfl_pkg::sat_add64(t0, t1);
      cdfl_pkg::ALU_AVAIL:    t0 <= avail;
      default: ;
    endcase
    unique case (cmd.res)
      cdfl_pkg::RES_PASS: begin
        res_flux <= cdfl_pkg::sat32(flux_sum);
        res_lim  <= 1'b0;
      end
      cdfl_pkg::RES_DIV: begin
        res_flux <= {1'b0, div_q};
        res_lim  <= 1'b1;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      deposition_flux <= res_flux;
      was_limited     <= res_lim;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.pot_gt   = tp > t0;
  assign sts.out_free = !result_valid || !result_stall;

endmodule

`default_nettype wire

// ===== rtl/cdfl_ctrl.sv =====
// Controller: takes input words, runs the product sequence of geometry, solid
// and finish words, then a finish's compare, divide, result hand-off. Uses cdfl_pkg.
`default_nettype none

module cdfl_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic [cdfl_pkg::OP_W-1:0]   opcode,
  output cdfl_pkg::cmd_t                   cmd,
  input  wire cdfl_pkg::sts_t              sts
);

  cdfl_pkg::state_t            state;
  cdfl_pkg::state_t            state_next;
  logic [cdfl_pkg::PC_W-1:0]   pc;
  logic [cdfl_pkg::PC_W-1:0]   pc_next;
  cdfl_pkg::uop_t              u;
  cdfl_pkg::state_t            after_step;

  assign u = cdfl_pkg::ucode(pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdfl_pkg::ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.a_sel  = u.a_sel;
    cmd.b_sel  = u.b_sel;
    cmd.dst    = u.dst;
    state_next = state;
    pc_next    = pc;
    item_stall = (state != cdfl_pkg::ST_IDLE);

    if (u.last) begin
      after_step = u.fin ? cdfl_pkg::ST_CMP : cdfl_pkg::ST_IDLE;
    end else begin
      after_step = cdfl_pkg::ST_ISSUE;
    end

    unique case (state)
      cdfl_pkg::ST_IDLE: begin
        if (item_valid) begin
          cmd.latch_in = 1'b1;
          unique case (cdfl_pkg::op_t'(opcode))
            cdfl_pkg::OP_GEOM: begin
              pc_next    = cdfl_pkg::PC_GEOM;
              state_next = cdfl_pkg::ST_ISSUE;
            end
            cdfl_pkg::OP_START:  cmd.alu = cdfl_pkg::ALU_START_CHEM;
            cdfl_pkg::OP_SOLID: begin
              pc_next    = cdfl_pkg::PC_SOLID;
              state_next = cdfl_pkg::ST_ISSUE;
            end
            cdfl_pkg::OP_LOSS:   cmd.alu = cdfl_pkg::ALU_ACC_LOSS;
            cdfl_pkg::OP_FINISH: begin
              pc_next    = cdfl_pkg::PC_FINISH;
              state_next = cdfl_pkg::ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      cdfl_pkg::ST_ISSUE: begin
        cmd.mul_start = 1'b1;
        state_next    = cdfl_pkg::ST_WAIT;
      end
      cdfl_pkg::ST_WAIT: begin
        if (sts.mul_done) begin
          cmd.mul_wr = 1'b1;
          if (u.alu != cdfl_pkg::ALU_NONE) begin
            state_next = cdfl_pkg::ST_ALU;
          end else begin
            state_next = after_step;
            if (!u.last) begin
              pc_next = pc + 1'b1;
            end
          end
        end
      end
      cdfl_pkg::ST_ALU: begin
        cmd.alu    = u.alu;
        state_next = after_step;
        if (!u.last) begin
          pc_next = pc + 1'b1;
        end
      end
      cdfl_pkg::ST_CMP: begin
        // Limit only when the mass the flux would move exceeds what is there.
        if (sts.pot_gt) begin
          cmd.div_start = 1'b1;
          state_next    = cdfl_pkg::ST_DIV;
        end else begin
          cmd.res    = cdfl_pkg::RES_PASS;
          state_next = cdfl_pkg::ST_OUT;
        end
      end
      cdfl_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.res    = cdfl_pkg::RES_DIV;
          state_next = cdfl_pkg::ST_OUT;
        end
      end
      cdfl_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = cdfl_pkg::ST_IDLE;
        end
      end
      default: state_next = cdfl_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/channel_deposition_flux_limiter.sv =====
// Top level of the channel deposition flux limiter: controller and datapath.
// Uses cdfl_pkg, cdfl_ctrl and cdfl_datapath.
`default_nettype none

// Computes one chemical's deposition flux at a channel node and limits it to
// the mass held in the water column, in signed fixed point with FRAC_BITS
// fraction bits. Start-chemical and loss words are handled as they are
// accepted, with no product. All products go through one shared multiplier,
// which geometry, solid and finish words use in turn. A finish word runs the
// one-bit-a-cycle divider only when the flux is limited. The result sits
// in an output register, so further words are taken while it waits; only the
// next finish waits for it to leave. The time step register should be
// written only while the block is idle.
module channel_deposition_flux_limiter #(
  parameter int FRAC_BITS = cdfl_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cdfl_pkg::TS_W-1:0]     cfg_data,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [cdfl_pkg::OP_W-1:0]     opcode,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    water_depth,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    bank_height,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    side_slope,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    top_width,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    bottom_width,
  input  wire logic [cdfl_pkg::GEO_W-1:0]    reach_length,
  input  wire logic signed [31:0]            concentration,
  input  wire logic signed [31:0]            deposition_flow,
  input  wire logic [cdfl_pkg::PFRAC_W-1:0]  particulate_fraction,
  input  wire logic signed [31:0]            loss_flux,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [31:0]                 deposition_flux,
  output logic                               was_limited
);

  cdfl_pkg::cmd_t cmd;
  cdfl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cdfl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .opcode     (opcode),
    .cmd        (cmd),
    .sts        (sts)
  );

  cdfl_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_data             (cfg_data),
    .water_depth          (water_depth),
    .bank_height          (bank_height),
    .side_slope           (side_slope),
    .top_width            (top_width),
    .bottom_width         (bottom_width),
    .reach_length         (reach_length),
    .concentration        (concentration),
    .deposition_flow      (deposition_flow),
    .particulate_fraction (particulate_fraction),
    .loss_flux            (loss_flux),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .deposition_flux      (deposition_flux),
    .was_limited          (was_limited)
  );

endmodule

`default_nettype wire
